>>> hdl/debounced_back_key_with_pin_autodetect_top_defines.svh
// assertion macros shared by the back-key debouncer modules
// the using module provides clk and rst
`ifndef DEBOUNCED_BACK_KEY_WITH_PIN_AUTODETECT_TOP_DEFINES_SVH
`define DEBOUNCED_BACK_KEY_WITH_PIN_AUTODETECT_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define DBK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DBK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dbk_pkg.sv
// types, codes and constants of the back-key debouncer with pin detection
// used by every module of the block but dbk_ram, no dependencies
package dbk_pkg;

  localparam int NUM_PINS_DEF = 32;
  localparam int MAX_CAND_DEF = 32;
  localparam int LEVEL_W      = 32;
  localparam int LVL_IDX_W    = 5;
  localparam int WORD_W       = 10;

  localparam logic [7:0]  PIN_NONE      = 8'hFF;
  localparam logic [7:0]  CNT_MAX       = 8'hFF;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
  localparam logic [7:0]  SETTLE_RST    = 8'd2;
  localparam logic [15:0] DET_LIMIT_RST = 16'd400;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PRESS   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_SHORT   = 3'd2,
    KIND_FOUND   = 3'd3,
    KIND_FAILED  = 3'd4,
    KIND_STARTED = 3'd5,
    KIND_REFUSED = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    REG_KEY_ENABLE   = 3'd0,
    REG_KEY_PIN      = 3'd1,
    REG_RESERVED     = 3'd2,
    REG_SETTLE       = 3'd3,
    REG_DETECT_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_FILL,
    T_SCAN,
    T_ELAPSE,
    T_KEY
  } top_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_SCAN
  } scan_state_t;

  typedef struct packed {
    logic fill_go;
    logic scan_go;
  } scan_ctl_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic       no_cand;
    logic [7:0] found_pin;
  } scan_sts_t;

  typedef struct packed {
    logic press;
    logic rel_ev;
    logic short_ev;
  } key_ev_t;

  typedef struct packed {
    logic [1:0]      n;
    kind_t [2:0]     kinds;
    logic [7:0]      pin;
  } batch_t;

endpackage

>>> hdl/dbk_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dbk_scan.sv
// pin-serial candidate engine: fills and debounces one pin per cycle
// depends on dbk_pkg and dbk_ram
module dbk_scan import dbk_pkg::*; #(
  parameter int NUM_PINS       = NUM_PINS_DEF,
  parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  logic [LEVEL_W-1:0] levels,
  input  logic [LEVEL_W-1:0] reserved,
  input  logic [7:0]         settle,
  output scan_sts_t          sts
);

  localparam int IDX_W  = $clog2(NUM_PINS + 1);
  localparam int AW     = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int CAND_W = $clog2(MAX_CANDIDATES + 1);

  scan_state_t state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               proc_v, proc_v_next;
  logic [AW-1:0]      proc_idx, proc_idx_next;
  logic [LEVEL_W-1:0] lvl_sr, lvl_sr_next;
  logic [LEVEL_W-1:0] rsv_sr, rsv_sr_next;
  logic [CAND_W-1:0]  ncand, ncand_next;
  scan_sts_t          sts_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  logic       issue, pr, fill_cand, w_cand, w_stable, hit;
  logic [7:0] w_cnt, cnt_inc;

  dbk_ram #(.WIDTH(WORD_W), .DEPTH(NUM_PINS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign w_cand    = rdata[9];
  assign w_stable  = rdata[8];
  assign w_cnt     = rdata[7:0];
  assign cnt_inc   = (w_cnt == CNT_MAX) ? CNT_MAX : w_cnt + 8'd1;
  assign pr        = ~lvl_sr[0];
  assign issue     = idx < IDX_W'(NUM_PINS);
  assign fill_cand = ~rsv_sr[0] && (ncand < CAND_W'(MAX_CANDIDATES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      proc_v <= 1'b0;
      sts    <= '0;
    end else begin
      state  <= state_next;
      proc_v <= proc_v_next;
      sts    <= sts_next;
    end
    idx      <= idx_next;
    proc_idx <= proc_idx_next;
    lvl_sr   <= lvl_sr_next;
    rsv_sr   <= rsv_sr_next;
    ncand    <= ncand_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    proc_v_next   = 1'b0;
    proc_idx_next = proc_idx;
    lvl_sr_next   = lvl_sr;
    rsv_sr_next   = rsv_sr;
    ncand_next    = ncand;
    sts_next      = sts;
    sts_next.done = 1'b0;
    we            = 1'b0;
    waddr         = idx[AW-1:0];
    wdata         = '0;
    hit           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (ctl.fill_go) begin
          state_next  = S_FILL;
          idx_next    = '0;
          lvl_sr_next = levels;
          rsv_sr_next = reserved;
          ncand_next  = '0;
        end else if (ctl.scan_go) begin
          state_next  = S_SCAN;
          idx_next    = '0;
          lvl_sr_next = levels;
        end
      end
      S_FILL: begin
        we          = 1'b1;
        waddr       = idx[AW-1:0];
        wdata       = {fill_cand, pr, 8'd0};
        lvl_sr_next = {1'b1, lvl_sr[LEVEL_W-1:1]};
        rsv_sr_next = {1'b0, rsv_sr[LEVEL_W-1:1]};
        idx_next    = idx + IDX_W'(1);
        if (fill_cand) begin
          ncand_next = ncand + CAND_W'(1);
        end
        if (idx == IDX_W'(NUM_PINS - 1)) begin
          state_next       = S_IDLE;
          sts_next.done    = 1'b1;
          sts_next.no_cand = (ncand == '0) && !fill_cand;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_next = idx + IDX_W'(1);
        end
        proc_v_next   = issue;
        proc_idx_next = idx[AW-1:0];
        if (proc_v) begin
          lvl_sr_next = {1'b1, lvl_sr[LEVEL_W-1:1]};
          waddr       = proc_idx;
          if (w_cand) begin
            we = 1'b1;
            if (pr == w_stable) begin
              wdata = {1'b1, w_stable, 8'd0};
            end else if (cnt_inc < settle) begin
              wdata = {1'b1, w_stable, cnt_inc};
            end else begin
              wdata = {1'b1, pr, 8'd0};
              hit   = pr;
            end
          end
          if (hit) begin
            state_next         = S_IDLE;
            proc_v_next        = 1'b0;
            sts_next.done      = 1'b1;
            sts_next.found     = 1'b1;
            sts_next.found_pin = 8'(proc_idx);
          end else if (proc_idx == AW'(NUM_PINS - 1)) begin
            state_next     = S_IDLE;
            proc_v_next    = 1'b0;
            sts_next.done  = 1'b1;
            sts_next.found = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/dbk_key.sv
// back-key debouncer with press, release and short events
// depends on dbk_pkg
module dbk_key import dbk_pkg::*; #(
  parameter int NUM_PINS = NUM_PINS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       active,
  input  logic       key_pr,
  input  logic       key_enable,
  input  logic [7:0] key_pin,
  input  logic [7:0] settle,
  output key_ev_t    ev
);

  logic [7:0] tracked, tracked_next;
  logic       stable, stable_next;
  logic [7:0] count, count_next;
  logic       was, was_next;
  logic [7:0] cnt_inc;

  assign cnt_inc = (count == CNT_MAX) ? CNT_MAX : count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked <= PIN_NONE;
      stable  <= 1'b0;
      count   <= 8'd0;
      was     <= 1'b0;
    end else begin
      tracked <= tracked_next;
      stable  <= stable_next;
      count   <= count_next;
      was     <= was_next;
    end
  end

  always_comb begin
    tracked_next = tracked;
    stable_next  = stable;
    count_next   = count;
    was_next     = was;
    ev           = '0;
    if (step && active) begin
      if (!key_enable || key_pin == PIN_NONE || key_pin >= 8'(NUM_PINS)) begin
        tracked_next = PIN_NONE;
        stable_next  = 1'b0;
        count_next   = 8'd0;
        was_next     = 1'b0;
      end else if (key_pin != tracked) begin
        tracked_next = key_pin;
        stable_next  = key_pr;
        count_next   = 8'd0;
        was_next     = key_pr;
      end else if (key_pr == stable) begin
        count_next = 8'd0;
      end else if (cnt_inc < settle) begin
        count_next = cnt_inc;
      end else begin
        count_next  = 8'd0;
        stable_next = key_pr;
        if (key_pr) begin
          ev.press = 1'b1;
          was_next = 1'b1;
        end else begin
          ev.rel_ev   = 1'b1;
          ev.short_ev = was;
          was_next    = 1'b0;
        end
      end
    end
  end

endmodule

>>> hdl/dbk_evq.sv
// result queue: holds up to three results of one request and the output register
// depends on dbk_pkg and the assertion macro header
`include "debounced_back_key_with_pin_autodetect_top_defines.svh"
module dbk_evq import dbk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  batch_t     batch,
  output logic       empty,
  output logic       result_valid,
  input  logic       result_stall,
  output kind_t      result_kind,
  output logic [7:0] found_pin,
  output logic       last
);

  kind_t [2:0] pend_kinds;
  logic [1:0]  pend_n;
  logic [7:0]  pend_pin;
  logic        pop;

  assign empty = (pend_n == 2'd0);
  assign pop   = !empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_n       <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (push) begin
        pend_n <= batch.n;
      end else if (pop) begin
        pend_n <= pend_n - 2'd1;
      end
      if (pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (push) begin
      pend_kinds <= batch.kinds;
      pend_pin   <= batch.pin;
    end else if (pop) begin
      pend_kinds <= {pend_kinds[2], pend_kinds[2], pend_kinds[1]};
    end
    if (pop) begin
      result_kind <= pend_kinds[0];
      found_pin   <= (pend_kinds[0] == KIND_FOUND) ? pend_pin : PIN_NONE;
      last        <= (pend_n == 2'd1);
    end
  end

  `DBK_ASSERT_NOW(a_push_empty, push, pend_n == 2'd0, "results pushed over a pending batch")
  `DBK_ASSERT_NOW(a_pin_none, result_valid && result_kind != KIND_FOUND,
                  found_pin == PIN_NONE, "pin given on a result other than found")

endmodule

>>> hdl/debounced_back_key_with_pin_autodetect_top.sv
// Back-key debouncer with pin auto-detection, top level.
// Depends on dbk_pkg, dbk_scan, dbk_key, dbk_evq and the assertion macro header.
//
// Input channel (item_valid/item_stall) carries a command (tick, start, cancel)
// and a 32-bit snapshot of pin levels, low meaning pressed. Results leave on
// the result channel (result_valid/result_stall) one at a time; last marks the
// final result of a request. Registers are written over cfg_valid/cfg_ready,
// always ready; the user must write them only while the block is idle, the block itself does not enforce it.
// A tick outside detection goes straight to the key step. A tick during
// detection first walks the per-pin counter memory one pin a cycle; a start
// sweeps the memory to load the candidates. Cancel and refused starts are
// handled in the idle state.
// A new request is taken once the previous one has finished and its results
// have moved to the output register, so it overlaps the last result waiting.
// When the receiver stalls, the output register holds and further results
// wait in the queue; the input stalls until the queue has drained.
// Reset returns the registers to their defaults, ends detection and clears
// the back-key state; the candidate memory is loaded at each start.
`include "debounced_back_key_with_pin_autodetect_top_defines.svh"
module debounced_back_key_with_pin_autodetect_top import dbk_pkg::*; #(
  parameter int NUM_PINS       = NUM_PINS_DEF,
  parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [LEVEL_W-1:0] pin_levels,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         result_kind,
  output logic [7:0]         found_pin,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  top_state_t state, state_next;

  logic         key_enable;
  logic [7:0]   key_pin;
  logic [31:0]  reserved_mask;
  logic [7:0]   settle_ticks;
  logic [15:0]  detect_limit_ticks;

  logic         detecting, detecting_next;
  logic [15:0]  elapsed, elapsed_next, el_inc;
  logic         det_v, det_v_next;
  kind_t        det_kind, det_kind_next;
  logic [7:0]   det_pin, det_pin_next;
  logic         key_pr, key_pr_next;

  logic         accept, q_empty, push;
  batch_t       batch;
  scan_ctl_t    sc_ctl;
  scan_sts_t    sc_sts;
  key_ev_t      key_ev;
  kind_t        kind_out;

  assign cfg_ready   = 1'b1;
  assign item_stall  = !(state == T_IDLE && q_empty);
  assign accept      = item_valid && !item_stall;
  assign el_inc      = (elapsed == ELAPSED_MAX) ? ELAPSED_MAX : elapsed + 16'd1;
  assign result_kind = kind_out;

  dbk_scan #(.NUM_PINS(NUM_PINS), .MAX_CANDIDATES(MAX_CANDIDATES)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sc_ctl),
    .levels   (pin_levels),
    .reserved (reserved_mask),
    .settle   (settle_ticks),
    .sts      (sc_sts)
  );

  dbk_key #(.NUM_PINS(NUM_PINS)) u_key (
    .clk        (clk),
    .rst        (rst),
    .step       (state == T_KEY),
    .active     (!detecting),
    .key_pr     (key_pr),
    .key_enable (key_enable),
    .key_pin    (key_pin),
    .settle     (settle_ticks),
    .ev         (key_ev)
  );

  dbk_evq u_evq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .batch        (batch),
    .empty        (q_empty),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (kind_out),
    .found_pin    (found_pin),
    .last         (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable         <= 1'b0;
      key_pin            <= PIN_NONE;
      reserved_mask      <= 32'd0;
      settle_ticks       <= SETTLE_RST;
      detect_limit_ticks <= DET_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_ENABLE:   key_enable         <= cfg_data[0];
        REG_KEY_PIN:      key_pin            <= cfg_data[7:0];
        REG_RESERVED:     reserved_mask      <= cfg_data;
        REG_SETTLE:       settle_ticks       <= cfg_data[7:0];
        REG_DETECT_LIMIT: detect_limit_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      detecting <= 1'b0;
      elapsed   <= 16'd0;
      det_v     <= 1'b0;
    end else begin
      state     <= state_next;
      detecting <= detecting_next;
      elapsed   <= elapsed_next;
      det_v     <= det_v_next;
    end
    det_kind <= det_kind_next;
    det_pin  <= det_pin_next;
    key_pr   <= key_pr_next;
  end

  always_comb begin
    logic [1:0] slot;
    state_next     = state;
    detecting_next = detecting;
    elapsed_next   = elapsed;
    det_v_next     = det_v;
    det_kind_next  = det_kind;
    det_pin_next   = det_pin;
    key_pr_next    = key_pr;
    sc_ctl         = '0;
    push           = 1'b0;
    batch.n        = 2'd0;
    batch.kinds    = {KIND_REFUSED, KIND_REFUSED, KIND_REFUSED};
    batch.pin      = PIN_NONE;
    slot           = 2'd0;
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_TICK: begin
              key_pr_next = (key_pin < 8'(LEVEL_W)) ? ~pin_levels[key_pin[LVL_IDX_W-1:0]]
                                                    : 1'b0;
              det_v_next  = 1'b0;
              if (detecting) begin
                sc_ctl.scan_go = 1'b1;
                state_next     = T_SCAN;
              end else begin
                state_next = T_KEY;
              end
            end
            CMD_START: begin
              if (detecting) begin
                push           = 1'b1;
                batch.n        = 2'd1;
                batch.kinds[0] = KIND_REFUSED;
              end else begin
                sc_ctl.fill_go = 1'b1;
                state_next     = T_FILL;
              end
            end
            CMD_CANCEL: detecting_next = 1'b0;
            default: ;
          endcase
        end
      end
      T_FILL: begin
        if (sc_sts.done) begin
          push       = 1'b1;
          state_next = T_IDLE;
          if (sc_sts.no_cand) begin
            batch.n        = 2'd2;
            batch.kinds[0] = KIND_FAILED;
            batch.kinds[1] = KIND_REFUSED;
          end else begin
            detecting_next = 1'b1;
            elapsed_next   = 16'd0;
            batch.n        = 2'd1;
            batch.kinds[0] = KIND_STARTED;
          end
        end
      end
      T_SCAN: begin
        if (sc_sts.done) begin
          if (sc_sts.found) begin
            detecting_next = 1'b0;
            det_v_next     = 1'b1;
            det_kind_next  = KIND_FOUND;
            det_pin_next   = sc_sts.found_pin;
            state_next     = T_KEY;
          end else begin
            state_next = T_ELAPSE;
          end
        end
      end
      T_ELAPSE: begin
        elapsed_next = el_inc;
        if (el_inc >= detect_limit_ticks) begin
          detecting_next = 1'b0;
          det_v_next     = 1'b1;
          det_kind_next  = KIND_FAILED;
          det_pin_next   = PIN_NONE;
        end
        state_next = T_KEY;
      end
      T_KEY: begin
        if (det_v) begin
          batch.kinds[slot] = det_kind;
          batch.pin         = det_pin;
          slot              = slot + 2'd1;
        end
        if (key_ev.press) begin
          batch.kinds[slot] = KIND_PRESS;
          slot              = slot + 2'd1;
        end
        if (key_ev.rel_ev) begin
          batch.kinds[slot] = KIND_RELEASE;
          slot              = slot + 2'd1;
        end
        if (key_ev.short_ev) begin
          batch.kinds[slot] = KIND_SHORT;
          slot              = slot + 2'd1;
        end
        batch.n    = slot;
        push       = (slot != 2'd0);
        state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  `DBK_ASSERT_NEXT(a_key_returns, state == T_KEY, state == T_IDLE,
                   "key step did not return to idle")
  `DBK_ASSERT_NOW(a_done_waiting, sc_sts.done, state == T_FILL || state == T_SCAN,
                  "scan finished while nothing waited for it")
  `DBK_ASSERT_NEXT(a_found_ends, state == T_SCAN && sc_sts.done && sc_sts.found,
                   !detecting, "detection still active after a pin was found")

endmodule
